// File: sv/l2_frame_ip_classifier_assert.svh
`ifndef L2_FRAME_IP_CLASSIFIER_ASSERT_SVH
`define L2_FRAME_IP_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, checked on clk and held off while rst_n is low.
`define L2IPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and held off while rst_n is low.
`define L2IPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/l2ipc_pkg.sv
package l2ipc_pkg;

  // Link encapsulation codes held in the configuration register.
  localparam logic [1:0] LINK_ETH    = 2'd0;
  localparam logic [1:0] LINK_RAW    = 2'd1;
  localparam logic [1:0] LINK_COOKED = 2'd2;

  // Frame classes reported on the result channel.
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_V4   = 2'd1;
  localparam logic [1:0] CLS_V6   = 2'd2;

  localparam logic [15:0] ET_IPV4   = 16'h0800;
  localparam logic [15:0] ET_IPV6   = 16'h86DD;
  localparam logic [15:0] ET_VLAN   = 16'h8100;
  localparam logic [15:0] ET_QINQ   = 16'h88A8;
  localparam logic [15:0] ET_MPLS_U = 16'h8847;
  localparam logic [15:0] ET_MPLS_M = 16'h8848;

  localparam logic [7:0]  VER_MASK = 8'hF0;
  localparam logic [7:0]  VER_4    = 8'h40;
  localparam logic [7:0]  VER_6    = 8'h60;

  localparam logic [19:0] LABEL_V4 = 20'd0;
  localparam logic [19:0] LABEL_V6 = 20'd2;

  // Hardware type 1 and address length 6 of the cooked capture header.
  localparam logic [31:0] COOKED_HDR = 32'h0001_0006;

  localparam int RAW_MIN_LEN = 20;
  localparam int OUT_W       = 16;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_ETYPE   = 5'b00010,
    PH_MPLS    = 5'b00100,
    PH_VERSION = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0]       frame_class;
    logic [OUT_W-1:0] payload_offset;
    logic [OUT_W-1:0] payload_length;
  } result_t;

endpackage

// File: sv/l2ipc_parser.sv
module l2ipc_parser import l2ipc_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [7:0]    frame_byte,
  input  logic          frame_last,
  input  logic [1:0]    link_type,
  output result_t       res
);

  localparam int L   = LENGTH_BITS;
  localparam int EXT = (L > OUT_W) ? L : OUT_W;
  localparam logic [L-1:0] LMAX = {L{1'b1}};

  logic [L-1:0]  pos_r, pos_nxt;
  logic [L-1:0]  nfo_r, nfo_nxt;
  phase_t        phase_r, phase_nxt;
  logic [31:0]   recent_r, recent_nxt;
  logic [1:0]    cls_r, cls_nxt;
  logic [L-1:0]  doff_r, doff_nxt;

  function automatic logic [L-1:0] sat_add(input logic [L-1:0] a, input logic [2:0] k);
    logic [L:0] s;
    s = {1'b0, a} + (L+1)'(k);
    return s[L] ? LMAX : s[L-1:0];
  endfunction

  logic [L-1:0]  p;
  logic          parse;
  phase_t        ph_w;
  logic [L-1:0]  nfo_w;
  logic [L+1:0]  p_x, nfo_x;
  logic [15:0]   etype;
  logic [19:0]   label;
  logic [L-1:0]  mpls_next;
  logic [L-1:0]  count;
  logic          ok;
  logic [EXT-1:0] off_e, len_e;

  always_comb begin
    p          = pos_r;
    parse      = (p != LMAX);
    recent_nxt = {recent_r[23:0], frame_byte};
    etype      = recent_nxt[15:0];
    label      = recent_nxt[23:4];
    pos_nxt    = parse ? p + L'(1) : p;
    phase_nxt  = phase_r;
    nfo_nxt    = nfo_r;
    cls_nxt    = cls_r;
    doff_nxt   = doff_r;
    ph_w       = phase_r;
    nfo_w      = nfo_r;

    // The first byte of a frame picks the parse path from the link type.
    if (p == '0) begin
      case (link_type)
        LINK_ETH: begin
          ph_w  = PH_ETYPE;
          nfo_w = L'(12);
        end
        LINK_RAW: begin
          ph_w  = PH_VERSION;
          nfo_w = '0;
        end
        LINK_COOKED: begin
          ph_w  = PH_ETYPE;
          nfo_w = L'(14);
        end
        default: begin
          ph_w = PH_DONE;
        end
      endcase
    end

    p_x       = {2'b00, p};
    nfo_x     = {2'b00, nfo_w};
    mpls_next = sat_add(nfo_w, 3'd4);

    if (parse) begin
      phase_nxt = ph_w;
      nfo_nxt   = nfo_w;
      if (p == '0 && ph_w == PH_DONE) begin
        cls_nxt  = CLS_NONE;
        doff_nxt = '0;
      end
      case (ph_w)
        PH_ETYPE: begin
          if (p == L'(5) && nfo_w == L'(14) && recent_nxt != COOKED_HDR) begin
            phase_nxt = PH_DONE;
            cls_nxt   = CLS_NONE;
            doff_nxt  = '0;
          end else if (p_x == nfo_x + (L+2)'(1)) begin
            if (etype == ET_IPV4) begin
              phase_nxt = PH_DONE;
              cls_nxt   = CLS_V4;
              doff_nxt  = sat_add(nfo_w, 3'd2);
            end else if (etype == ET_IPV6) begin
              phase_nxt = PH_DONE;
              cls_nxt   = CLS_V6;
              doff_nxt  = sat_add(nfo_w, 3'd2);
            end else if (etype == ET_VLAN || etype == ET_QINQ) begin
              nfo_nxt = sat_add(nfo_w, 3'd4);
            end else if (etype == ET_MPLS_U || etype == ET_MPLS_M) begin
              nfo_nxt   = sat_add(nfo_w, 3'd2);
              phase_nxt = PH_MPLS;
            end else begin
              phase_nxt = PH_DONE;
              cls_nxt   = CLS_NONE;
              doff_nxt  = '0;
            end
          end
        end
        PH_MPLS: begin
          if (p_x == nfo_x + (L+2)'(2)) begin
            // Bit 0 of the third label byte is the bottom-of-stack flag.
            if (recent_nxt[0]) begin
              if (label == LABEL_V4) begin
                phase_nxt = PH_DONE;
                cls_nxt   = CLS_V4;
                doff_nxt  = mpls_next;
              end else if (label == LABEL_V6) begin
                phase_nxt = PH_DONE;
                cls_nxt   = CLS_V6;
                doff_nxt  = mpls_next;
              end else begin
                nfo_nxt   = mpls_next;
                phase_nxt = PH_VERSION;
              end
            end else begin
              nfo_nxt = mpls_next;
            end
          end
        end
        PH_VERSION: begin
          if (p == nfo_w) begin
            phase_nxt = PH_DONE;
            if ((frame_byte & VER_MASK) == VER_4) begin
              cls_nxt  = CLS_V4;
              doff_nxt = nfo_w;
            end else if ((frame_byte & VER_MASK) == VER_6) begin
              cls_nxt  = CLS_V6;
              doff_nxt = nfo_w;
            end else begin
              cls_nxt  = CLS_NONE;
              doff_nxt = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // Frame verdict, formed from the state as it stands after this byte.
    count = pos_nxt;
    ok    = (cls_nxt != CLS_NONE) && (count > doff_nxt) &&
            ((doff_nxt != '0) || (EXT'(count) > EXT'(RAW_MIN_LEN)));
    off_e = ok ? EXT'(doff_nxt) : '0;
    len_e = ok ? EXT'(count - doff_nxt) : '0;
    res.frame_class    = ok ? cls_nxt : CLS_NONE;
    res.payload_offset = (off_e > EXT'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : off_e[OUT_W-1:0];
    res.payload_length = (len_e > EXT'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : len_e[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      nfo_r    <= '0;
      phase_r  <= PH_HEADER;
      recent_r <= '0;
      cls_r    <= CLS_NONE;
      doff_r   <= '0;
    end else if (en) begin
      if (frame_last) begin
        pos_r    <= '0;
        nfo_r    <= '0;
        phase_r  <= PH_HEADER;
        recent_r <= '0;
        cls_r    <= CLS_NONE;
        doff_r   <= '0;
      end else begin
        pos_r    <= pos_nxt;
        nfo_r    <= nfo_nxt;
        phase_r  <= phase_nxt;
        recent_r <= recent_nxt;
        cls_r    <= cls_nxt;
        doff_r   <= doff_nxt;
      end
    end
  end

endmodule

// File: sv/l2ipc_out_stage.sv
module l2ipc_out_stage import l2ipc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t out_res,
  output logic    free
);

  logic    vld_r;
  result_t res_r;

  assign free      = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// File: sv/l2_frame_ip_classifier.sv
// Layer-2 frame classifier. Frame bytes enter one word at a time on the in_
// stream, with in_tlast on the final byte. For every frame one result word
// leaves on the out_ stream after its last byte: class (ignored, IPv4, IPv6),
// the IP header offset and the captured length from there to frame end.
// Ethernet frames may carry any number of VLAN tags and an MPLS stack; raw IP
// and Linux cooked captures are handled as selected by cfg_wr_data, written
// with cfg_wr_en while no frame is in flight and sampled at each frame start.
// After the last byte is accepted it sits in the input register, and the result
// register is loaded from it once the output register is free.
// Throughput: one byte per cycle while in_tready is high, set by the per-byte parse state update.
// When the receiver stalls, the result holds in the output register and
// bytes keep flowing until another last byte needs that register; only then
// does in_tready drop. Reset (rst_n low, synchronous) clears the link type to
// ethernet, empties both registers and restarts at a frame boundary.
`include "l2_frame_ip_classifier_assert.svh"

module l2_frame_ip_classifier import l2ipc_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] frame_byte
  input  logic        in_tlast,    // frame_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [1:0] frame_class, [17:2] payload_offset,
                                   // [33:18] payload_length, [39:34] zero
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data  // link_type
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic [1:0] link_type_r;
  logic       consume;
  logic       out_free;
  result_t    res;
  result_t    out_res;

  // A buffered byte moves on unless it ends a frame and the result is blocked.
  assign consume   = in_vld_r && (!in_last_r || out_free);
  assign in_tready = !in_vld_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      link_type_r <= LINK_ETH;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (cfg_wr_en) begin
        link_type_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  l2ipc_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (consume),
    .frame_byte (in_byte_r),
    .frame_last (in_last_r),
    .link_type  (link_type_r),
    .res        (res)
  );

  l2ipc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (consume && in_last_r),
    .res       (res),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_res   (out_res),
    .free      (out_free)
  );

  assign out_tdata = {6'b0, out_res.payload_length, out_res.payload_offset,
                      out_res.frame_class};

  `L2IPC_ASSERT_NOW(a_ignored_is_zero,
    out_tvalid && out_res.frame_class == CLS_NONE,
    out_res.payload_offset == '0 && out_res.payload_length == '0,
    "ignored frame reported with nonzero offset or length")

  `L2IPC_ASSERT_NOW(a_class_has_payload,
    out_tvalid && out_res.frame_class != CLS_NONE,
    out_res.payload_length != '0,
    "classified frame reported with empty payload")

  `L2IPC_ASSERT_NOW(a_no_result_overwrite,
    consume && in_last_r,
    !out_tvalid || out_tready,
    "frame end parsed while the previous result is still held")

  `L2IPC_ASSERT_NEXT(a_stalled_byte_kept,
    in_vld_r && !consume,
    in_vld_r && $stable(in_byte_r) && $stable(in_last_r),
    "buffered byte lost while waiting for the result register")

endmodule
